// ===== rtl/tsc_pkg.sv =====
// Shared types, constants and a helper function for the TCP segment header checker.
package tsc_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned HDR_BYTES       = 20;
  localparam int unsigned PROTO_TCP       = 6;
  localparam int unsigned MID_DEPTH       = 2;
  localparam int unsigned OUT_DEPTH       = 2;
  localparam logic [1:0]  ECN_MASK        = 2'b11;

  localparam logic ACT_ADDR = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_FAMILY   = 3'd1,
    ERR_SHORT    = 3'd2,
    ERR_LONG     = 3'd3,
    ERR_OFFSET   = 3'd4,
    ERR_CHECKSUM = 3'd5
  } err_e;

  // Summary of one finished segment, handed from the front part to the back part.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [15:0]               sum;
    logic [7:0]                pend;
    logic [31:0]               len;
    logic                      saturated;
    logic [1:0]                family;
    logic [1:0]                ecn;
  } seg_t;

  typedef struct packed {
    err_e        error_code;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] urgent_offset;
    logic [1:0]  ecn_out;
    logic [5:0]  options_bytes;
    logic [31:0] payload_bytes;
  } result_t;

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'b0, t[16]};
  endfunction

endpackage

// ===== rtl/tsc_fifo.sv =====
// Small register-based queue with full and empty flags.
module tsc_fifo import tsc_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/tsc_front.sv =====
// Front part: takes address words and segment bytes, keeps the running sum and header bytes.
module tsc_front import tsc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic        action_i,
  input  logic [31:0] address_word_i,
  input  logic [7:0]  data_byte_i,
  input  logic        source_is_ipv6_i,
  input  logic        destination_is_ipv6_i,
  input  logic [1:0]  ecn_bits_i,
  input  logic        last_i,
  output logic        seg_push_o,
  output seg_t        seg_o
);

  localparam logic [LENGTH_BITS-1:0] CntMax = '1;

  logic [LENGTH_BITS-1:0]    count_q, count_d;
  logic [15:0]               sum_q, sum_d;
  logic [7:0]                pend_q, pend_d;
  logic [HDR_BYTES-1:0][7:0] hdr_q, hdr_d;
  logic [1:0]                family_q, family_d;
  logic [1:0]                ecn_q, ecn_d;
  logic                      first_q, first_d;

  always_comb begin
    count_d    = count_q;
    sum_d      = sum_q;
    pend_d     = pend_q;
    hdr_d      = hdr_q;
    family_d   = family_q;
    ecn_d      = ecn_q;
    first_d    = first_q;
    seg_push_o = 1'b0;

    if (valid_i) begin
      if (!first_q) begin
        family_d = {destination_is_ipv6_i, source_is_ipv6_i};
        ecn_d    = ecn_bits_i & ECN_MASK;
        first_d  = 1'b1;
      end
      if (action_i == ACT_ADDR) begin
        sum_d = oc_add(oc_add(sum_q, address_word_i[31:16]), address_word_i[15:0]);
      end else begin
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (count_q == LENGTH_BITS'(i)) begin
            hdr_d[i] = data_byte_i;
          end
        end
        // Bytes pair up big-endian: an even position waits for its partner.
        if (!count_q[0]) begin
          pend_d = data_byte_i;
        end else begin
          sum_d = oc_add(sum_q, {pend_q, data_byte_i});
        end
        if (count_q != CntMax) begin
          count_d = count_q + 1'b1;
        end
        seg_push_o = last_i;
      end
    end

    seg_o.hdr       = hdr_d;
    seg_o.sum       = sum_d;
    seg_o.pend      = pend_d;
    seg_o.len       = 32'(count_d);
    seg_o.saturated = (count_d == CntMax);
    seg_o.family    = family_d;
    seg_o.ecn       = ecn_d;

    // The segment is handed on; start the next one from scratch.
    if (seg_push_o) begin
      count_d = '0;
      sum_d   = '0;
      pend_d  = '0;
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      pend_q   <= '0;
      hdr_q    <= '0;
      family_q <= '0;
      ecn_q    <= '0;
      first_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      sum_q    <= sum_d;
      pend_q   <= pend_d;
      hdr_q    <= hdr_d;
      family_q <= family_d;
      ecn_q    <= ecn_d;
      first_q  <= first_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && action_i == ACT_BYTE && last_i |=> count_q == '0 && !first_q && sum_q == '0)
    else $error("segment state not cleared after the last byte");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && action_i == ACT_BYTE && !last_i |=> count_q != '0 && first_q)
    else $error("byte count did not advance on a segment byte");

  a_push_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_push_o |-> valid_i && action_i == ACT_BYTE && seg_o.len != '0)
    else $error("segment handed on without a last byte");

endmodule

// ===== rtl/tsc_back.sv =====
// Back part: runs the family, length, offset and checksum checks and forms the result.
module tsc_back import tsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  seg_t    seg_i,
  input  logic    seg_empty_i,
  output logic    seg_pop_o,
  output logic    res_push_o,
  output result_t res_o,
  input  logic    res_full_i
);

  typedef struct packed {
    err_e                      err;
    logic [15:0]               psum;
    logic                      v4;
    logic [31:0]               len;
    logic [5:0]                hl;
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic [1:0]                ecn;
  } stage_t;

  stage_t      s1_q, s1_d;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_ready;
  logic [15:0] pad;
  logic [15:0] fsum;
  err_e        err;

  assign s1_ready   = !s1_valid_q || !res_full_i;
  assign seg_pop_o  = !seg_empty_i && s1_ready;
  assign res_push_o = s1_valid_q && !res_full_i;

  // First step: ordered checks and the sum up to the protocol number.
  always_comb begin
    s1_d.hl   = {seg_i.hdr[12][7:4], 2'b00};
    s1_d.v4   = !seg_i.family[0];
    s1_d.len  = seg_i.len;
    s1_d.hdr  = seg_i.hdr;
    s1_d.ecn  = seg_i.ecn;
    pad       = seg_i.len[0] ? {seg_i.pend, 8'h00} : 16'h0000;
    s1_d.psum = oc_add(oc_add(seg_i.sum, pad), 16'(PROTO_TCP));
    priority if (seg_i.family[0] != seg_i.family[1]) begin
      s1_d.err = ERR_FAMILY;
    end else if (seg_i.len < 32'(HDR_BYTES)) begin
      s1_d.err = ERR_SHORT;
    end else if (seg_i.saturated || (!seg_i.family[0] && seg_i.len[31:16] != '0)) begin
      s1_d.err = ERR_LONG;
    end else if (s1_d.hl < 6'(HDR_BYTES) || 32'(s1_d.hl) > seg_i.len) begin
      s1_d.err = ERR_OFFSET;
    end else begin
      s1_d.err = ERR_NONE;
    end
  end

  // Second step: pseudo-header length words, checksum verdict and field extraction.
  always_comb begin
    if (s1_q.v4) begin
      fsum = oc_add(s1_q.psum, s1_q.len[15:0]);
    end else begin
      fsum = oc_add(oc_add(s1_q.psum, s1_q.len[31:16]), s1_q.len[15:0]);
    end
    if (s1_q.err != ERR_NONE) begin
      err = s1_q.err;
    end else if (fsum != 16'hFFFF) begin
      err = ERR_CHECKSUM;
    end else begin
      err = ERR_NONE;
    end

    res_o            = '0;
    res_o.error_code = err;
    if (err == ERR_NONE) begin
      res_o.src_port         = {s1_q.hdr[0], s1_q.hdr[1]};
      res_o.dst_port         = {s1_q.hdr[2], s1_q.hdr[3]};
      res_o.sequence_number  = {s1_q.hdr[4], s1_q.hdr[5], s1_q.hdr[6], s1_q.hdr[7]};
      res_o.ack_number       = {s1_q.hdr[8], s1_q.hdr[9], s1_q.hdr[10], s1_q.hdr[11]};
      res_o.flag_bits        = s1_q.hdr[13];
      res_o.window_size      = {s1_q.hdr[14], s1_q.hdr[15]};
      res_o.urgent_offset    = {s1_q.hdr[18], s1_q.hdr[19]};
      res_o.ecn_out          = s1_q.ecn;
      res_o.options_bytes    = s1_q.hl - 6'(HDR_BYTES);
      res_o.payload_bytes    = s1_q.len - 32'(s1_q.hl);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (seg_pop_o) begin
      s1_valid_d = 1'b1;
    end else if (res_push_o) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_pop_o) begin
      s1_q <= s1_d;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && res_full_i |=> s1_valid_q && $stable(s1_q))
    else $error("check stage lost or changed a request while stalled");

  a_error_zeroes_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.error_code != ERR_NONE |->
      res_o.src_port == '0 && res_o.payload_bytes == '0 && res_o.ecn_out == '0)
    else $error("error result carries header fields");

  a_early_check_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && s1_q.err != ERR_NONE |-> res_o.error_code == s1_q.err)
    else $error("checksum verdict overrode an earlier check");

endmodule

// ===== rtl/tcp_segment_header_checker.sv =====
// Top level of the TCP segment header checker: front part, segment queue, back part, result queue.
//
// Channel  Direction  Handshake           Payload
// input    in         push / full         action, address_word, data_byte, families, ecn, last
// result   out        empty / pop         error_code and parsed header fields
//
// One request is taken every clock cycle while full is low; the per-byte sum add and header
// latch in the front part are registered with each request.
// A result reaches the result ports through the segment queue, check stage and result queue.
// After reset both queues are empty and no result is pending; no clearing pass is needed.
// full rises only when the segment queue holds two finished segments that the back part
// cannot yet take because the result queue is not being popped.
module tcp_segment_header_checker import tsc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [31:0] address_word_i,
  input  logic [7:0]  data_byte_i,
  input  logic        source_is_ipv6_i,
  input  logic        destination_is_ipv6_i,
  input  logic [1:0]  ecn_bits_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  error_code_o,
  output logic [15:0] src_port_o,
  output logic [15:0] dst_port_o,
  output logic [31:0] sequence_number_o,
  output logic [31:0] ack_number_o,
  output logic [7:0]  flag_bits_o,
  output logic [15:0] window_size_o,
  output logic [15:0] urgent_offset_o,
  output logic [1:0]  ecn_out_o,
  output logic [5:0]  options_bytes_o,
  output logic [31:0] payload_bytes_o
);

  logic    accept;
  logic    seg_push;
  seg_t    seg_in, seg_out;
  logic    seg_empty, seg_pop;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign accept = push && !full;

  tsc_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .valid_i              (accept),
    .action_i             (action_i),
    .address_word_i       (address_word_i),
    .data_byte_i          (data_byte_i),
    .source_is_ipv6_i     (source_is_ipv6_i),
    .destination_is_ipv6_i(destination_is_ipv6_i),
    .ecn_bits_i           (ecn_bits_i),
    .last_i               (last_i),
    .seg_push_o           (seg_push),
    .seg_o                (seg_in)
  );

  tsc_fifo #(
    .Width($bits(seg_t)),
    .Depth(MID_DEPTH)
  ) u_seg_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (seg_push),
    .data_i (seg_in),
    .full_o (full),
    .pop_i  (seg_pop),
    .data_o (seg_out),
    .empty_o(seg_empty)
  );

  tsc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg_i      (seg_out),
    .seg_empty_i(seg_empty),
    .seg_pop_o  (seg_pop),
    .res_push_o (res_push),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  tsc_fifo #(
    .Width($bits(result_t)),
    .Depth(OUT_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign error_code_o       = res_out.error_code;
  assign src_port_o         = res_out.src_port;
  assign dst_port_o         = res_out.dst_port;
  assign sequence_number_o  = res_out.sequence_number;
  assign ack_number_o       = res_out.ack_number;
  assign flag_bits_o        = res_out.flag_bits;
  assign window_size_o      = res_out.window_size;
  assign urgent_offset_o    = res_out.urgent_offset;
  assign ecn_out_o          = res_out.ecn_out;
  assign options_bytes_o    = res_out.options_bytes;
  assign payload_bytes_o    = res_out.payload_bytes;

endmodule

// ===== tb/sv/tb_tcp_segment_header_checker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TCP segment header checker: table-driven and random segments.
module tb_tcp_segment_header_checker import tsc_pkg::*;;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned WORD_BYTES   = 4;
  localparam logic [31:0] SAT_COUNT    = 32'((64'd1 << LENGTH_BITS_DEF) - 64'd1);

  typedef enum int {CKS_GOOD, CKS_FLIPPED, CKS_RANDOM} cks_e;
  typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_HOLD} pop_mode_e;

  // One request toward the block, plus the typed-in error code where a row gives one.
  typedef struct packed {
    logic        act;
    logic [31:0] word;
    logic [7:0]  data;
    logic        src6;
    logic        dst6;
    logic [1:0]  ecn;
    logic        last;
    logic        typed;
    err_e        typed_err;
  } seg_item_t;

  typedef struct {
    bit   s6;
    bit   d6;
    int   ecn;
    int   n_addr;
    int   len;
    int   nib;
    cks_e cks;
    bit   mix;
    int   fill;
    err_e err;
  } seg_spec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_req = 1'b0;
  logic pop_req = 1'b0;
  seg_item_t drv = '0;
  logic full, empty;
  logic [2:0]  error_code_o;
  logic [15:0] src_port_o, dst_port_o, window_size_o, urgent_offset_o;
  logic [31:0] sequence_number_o, ack_number_o, payload_bytes_o;
  logic [7:0]  flag_bits_o;
  logic [1:0]  ecn_out_o;
  logic [5:0]  options_bytes_o;

  seg_item_t tx_q[$];
  result_t   awaited_results[$];
  int unsigned built_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  // Predictor state for the segment in progress.
  logic [31:0] seg_len_count = '0;
  logic [15:0] csum_acc = '0;
  logic [7:0]  hi_pending = '0;
  logic [7:0]  hdr_copy [HDR_BYTES] = '{default: 8'h00};
  logic [1:0]  fam_latch = '0;
  logic [1:0]  ecn_hold = '0;
  logic        seg_open = 1'b0;

  pop_mode_e   pop_mode = POP_ALWAYS;
  int unsigned pop_left = 0;

  always #2 clk_i = ~clk_i;

  tcp_segment_header_checker dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push_req),
    .full                 (full),
    .action_i             (drv.act),
    .address_word_i       (drv.word),
    .data_byte_i          (drv.data),
    .source_is_ipv6_i     (drv.src6),
    .destination_is_ipv6_i(drv.dst6),
    .ecn_bits_i           (drv.ecn),
    .last_i               (drv.last),
    .empty                (empty),
    .pop                  (pop_req),
    .error_code_o         (error_code_o),
    .src_port_o           (src_port_o),
    .dst_port_o           (dst_port_o),
    .sequence_number_o    (sequence_number_o),
    .ack_number_o         (ack_number_o),
    .flag_bits_o          (flag_bits_o),
    .window_size_o        (window_size_o),
    .urgent_offset_o      (urgent_offset_o),
    .ecn_out_o            (ecn_out_o),
    .options_bytes_o      (options_bytes_o),
    .payload_bytes_o      (payload_bytes_o)
  );

  function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = a + b;
    return t[15:0] + 16'(t[16]);
  endfunction

  function automatic seg_spec_t mk(input bit s6, input bit d6, input int ecn, input int n_addr,
                                   input int len, input int nib, input cks_e cks, input bit mix,
                                   input int fill, input err_e err);
    seg_spec_t sp;
    sp.s6 = s6;
    sp.d6 = d6;
    sp.ecn = ecn;
    sp.n_addr = n_addr;
    sp.len = len;
    sp.nib = nib;
    sp.cks = cks;
    sp.mix = mix;
    sp.fill = fill;
    sp.err = err;
    return sp;
  endfunction

  // Advances the header parser by one request and yields the result that a last byte closes.
  task automatic parse_segment_step(input seg_item_t it, output bit made, output result_t res);
    logic [31:0] pos, len;
    logic [15:0] s;
    int unsigned hl;
    bit          v4;
    err_e        e;
    made = 1'b0;
    res = '0;
    if (!seg_open) begin
      fam_latch = {it.dst6, it.src6};
      ecn_hold = it.ecn & ECN_MASK;
      seg_open = 1'b1;
    end
    if (it.act == ACT_ADDR) begin
      csum_acc = fold16(fold16(csum_acc, it.word[31:16]), it.word[15:0]);
      return;
    end
    pos = seg_len_count;
    if (pos < HDR_BYTES) hdr_copy[pos[4:0]] = it.data;
    if (!pos[0]) hi_pending = it.data;
    else csum_acc = fold16(csum_acc, {hi_pending, it.data});
    if (pos < SAT_COUNT) seg_len_count = pos + 32'd1;
    if (!it.last) return;

    len = seg_len_count;
    v4 = !fam_latch[0];
    hl = 0;
    e = ERR_NONE;
    if (fam_latch[0] != fam_latch[1]) begin
      e = ERR_FAMILY;
    end else if (len < HDR_BYTES) begin
      e = ERR_SHORT;
    end else if (len >= SAT_COUNT || (v4 && len > 32'h0000_FFFF)) begin
      e = ERR_LONG;
    end else begin
      hl = WORD_BYTES * hdr_copy[12][7:4];
      if (hl < HDR_BYTES || hl > len) begin
        e = ERR_OFFSET;
      end else begin
        s = csum_acc;
        if (len[0]) s = fold16(s, {hi_pending, 8'h00});
        s = fold16(s, 16'(PROTO_TCP));
        if (!v4) s = fold16(s, len[31:16]);
        s = fold16(s, len[15:0]);
        if (s != 16'hFFFF) e = ERR_CHECKSUM;
      end
    end
    res.error_code = e;
    if (e == ERR_NONE) begin
      res.src_port         = {hdr_copy[0], hdr_copy[1]};
      res.dst_port         = {hdr_copy[2], hdr_copy[3]};
      res.sequence_number  = {hdr_copy[4], hdr_copy[5], hdr_copy[6], hdr_copy[7]};
      res.ack_number       = {hdr_copy[8], hdr_copy[9], hdr_copy[10], hdr_copy[11]};
      res.flag_bits        = hdr_copy[13];
      res.window_size      = {hdr_copy[14], hdr_copy[15]};
      res.urgent_offset    = {hdr_copy[18], hdr_copy[19]};
      res.ecn_out          = ecn_hold;
      res.options_bytes    = 6'(hl - HDR_BYTES);
      res.payload_bytes    = len - hl;
    end
    made = 1'b1;
    seg_len_count = '0;
    csum_acc = '0;
    hi_pending = '0;
    seg_open = 1'b0;
  endtask

  // Queues the requests of one segment; the checksum field is fixed up so that a good one sums
  // to all ones.
  task automatic build_segment(input seg_spec_t sp);
    logic [7:0]  b[];
    logic [31:0] w[];
    logic [15:0] s;
    logic [31:0] n;
    seg_item_t   seg[$];
    seg_item_t   it;
    int          k;
    b = new[sp.len];
    w = new[sp.n_addr];
    for (k = 0; k < sp.len; k++) b[k] = (sp.fill < 0) ? 8'($urandom) : 8'(sp.fill);
    for (k = 0; k < sp.n_addr; k++) w[k] = (sp.fill < 0) ? $urandom : {4{8'(sp.fill)}};
    if (sp.len > 12) b[12] = {4'(sp.nib), b[12][3:0]};
    if (sp.len >= 18) begin
      b[16] = 8'h00;
      b[17] = 8'h00;
      s = 16'h0000;
      for (k = 0; k < sp.n_addr; k++) s = fold16(fold16(s, w[k][31:16]), w[k][15:0]);
      for (k = 0; k < sp.len; k += 2) s = fold16(s, {b[k], (k + 1 < sp.len) ? b[k+1] : 8'h00});
      n = sp.len;
      s = fold16(s, 16'(PROTO_TCP));
      if (sp.s6) s = fold16(s, n[31:16]);
      s = fold16(s, n[15:0]);
      s = ~s;
      case (sp.cks)
        CKS_FLIPPED: s = s ^ 16'($urandom_range(1, 16'hFFFF));
        CKS_RANDOM:  s = 16'($urandom);
        default:     ;
      endcase
      {b[16], b[17]} = s;
    end
    for (k = 0; k < sp.len; k++) begin
      it = '0;
      it.act = ACT_BYTE;
      it.data = b[k];
      it.word = $urandom;
      it.last = (k == sp.len - 1);
      seg.push_back(it);
    end
    for (k = 0; k < sp.n_addr; k++) begin
      it = '0;
      it.act = ACT_ADDR;
      it.word = w[k];
      it.data = 8'($urandom);
      it.last = 1'($urandom_range(0, 1));
      if (sp.mix) seg.insert($urandom_range(0, seg.size() - 1), it);
      else seg.push_front(it);
    end
    // Family and ECN only count on the first request; later ones carry noise there.
    for (k = 0; k < seg.size(); k++) begin
      seg[k].src6 = 1'($urandom_range(0, 1));
      seg[k].dst6 = 1'($urandom_range(0, 1));
      seg[k].ecn = 2'($urandom_range(0, 3));
      seg[k].typed = (sp.err != ERR_NONE);
      seg[k].typed_err = sp.err;
    end
    seg[0].src6 = sp.s6;
    seg[0].dst6 = sp.d6;
    seg[0].ecn = 2'(sp.ecn);
    built_items += seg.size();
    while (seg.size() != 0) tx_q.push_back(seg.pop_front());
  endtask

  // Pushes every queued request in bursts; push stays high when one burst runs into the next.
  task automatic send_all();
    int unsigned burst, gap;
    bit          took;
    while (tx_q.size() != 0) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      while (burst != 0 && tx_q.size() != 0) begin
        drv <= tx_q.pop_front();
        push_req <= 1'b1;
        do begin
          @(negedge clk_i);
          took = !full;
          @(posedge clk_i);
        end while (!took);
        burst--;
      end
      if (gap != 0 && tx_q.size() != 0) begin
        push_req <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_for_results();
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      mismatches++;
    end
  endtask

  // Receiver: pop follows a mode that changes after a random number of cycles.
  always @(posedge clk_i) begin
    if (pop_left == 0) begin
      pop_mode <= pop_mode_e'($urandom_range(0, 3));
      pop_left <= $urandom_range(8, 60);
    end else begin
      pop_left <= pop_left - 1;
    end
    case (pop_mode)
      POP_ALWAYS: pop_req <= 1'b1;
      POP_HALF:   pop_req <= 1'($urandom_range(0, 1));
      POP_SPARSE: pop_req <= ($urandom_range(0, 7) == 0);
      default:    pop_req <= 1'b0;
    endcase
  end

  // Results are checked before the request of the same edge is predicted: they belong to older
  // segments.
  always @(posedge clk_i) begin
    result_t want;
    result_t res;
    bit      made;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (pop_req && !empty) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual error_code %0d",
                   $time, error_code_o);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("error_code", 32'(want.error_code), 32'(error_code_o));
          check_field("src_port", 32'(want.src_port), 32'(src_port_o));
          check_field("dst_port", 32'(want.dst_port), 32'(dst_port_o));
          check_field("sequence_number", want.sequence_number, sequence_number_o);
          check_field("ack_number", want.ack_number, ack_number_o);
          check_field("flag_bits", 32'(want.flag_bits), 32'(flag_bits_o));
          check_field("window_size", 32'(want.window_size), 32'(window_size_o));
          check_field("urgent_offset", 32'(want.urgent_offset), 32'(urgent_offset_o));
          check_field("ecn_out", 32'(want.ecn_out), 32'(ecn_out_o));
          check_field("options_bytes", 32'(want.options_bytes), 32'(options_bytes_o));
          check_field("payload_bytes", want.payload_bytes, payload_bytes_o);
        end
      end
      if (push_req && !full) begin
        moved = 1'b1;
        parse_segment_step(drv, made, res);
        if (made) begin
          if (drv.typed) begin
            res = '0;
            res.error_code = drv.typed_err;
          end
          awaited_results.push_back(res);
        end
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < IDLE_LIMIT);
    $display("tcp_segment_header_checker verification failed");
    $finish;
  end

  initial begin
    seg_spec_t   plan[$];
    seg_spec_t   sp;
    int unsigned dir_items;
    int          kind, chunk;
    bit          six;

    //                 s6 d6 ecn addr len    nib cks          mix fill err
    plan.push_back(mk(0, 0, 0,  2,   1,     5,  CKS_GOOD,    0,  0,   ERR_SHORT));
    plan.push_back(mk(0, 0, 3,  2,   20,    5,  CKS_GOOD,    0,  0,   ERR_NONE));
    plan.push_back(mk(1, 1, 2,  8,   60,    15, CKS_GOOD,    0,  255, ERR_NONE));
    plan.push_back(mk(1, 0, 1,  8,   30,    5,  CKS_GOOD,    0,  -1,  ERR_FAMILY));
    plan.push_back(mk(0, 1, 0,  2,   5,     5,  CKS_GOOD,    0,  -1,  ERR_FAMILY));
    plan.push_back(mk(0, 1, 3,  2,   20,    4,  CKS_RANDOM,  0,  -1,  ERR_FAMILY));
    plan.push_back(mk(0, 0, 1,  2,   19,    5,  CKS_GOOD,    0,  -1,  ERR_SHORT));
    plan.push_back(mk(1, 1, 2,  8,   18,    5,  CKS_GOOD,    0,  -1,  ERR_SHORT));
    plan.push_back(mk(0, 0, 3,  2,   20,    4,  CKS_GOOD,    0,  -1,  ERR_OFFSET));
    plan.push_back(mk(0, 0, 0,  2,   40,    0,  CKS_RANDOM,  0,  -1,  ERR_OFFSET));
    plan.push_back(mk(1, 1, 1,  8,   40,    11, CKS_RANDOM,  0,  -1,  ERR_OFFSET));
    plan.push_back(mk(0, 0, 2,  2,   41,    5,  CKS_GOOD,    0,  -1,  ERR_NONE));
    plan.push_back(mk(0, 0, 2,  2,   41,    5,  CKS_FLIPPED, 0,  -1,  ERR_CHECKSUM));
    plan.push_back(mk(1, 1, 3,  8,   21,    5,  CKS_FLIPPED, 1,  -1,  ERR_CHECKSUM));
    plan.push_back(mk(0, 0, 1,  3,   33,    8,  CKS_GOOD,    1,  -1,  ERR_NONE));
    plan.push_back(mk(1, 1, 0,  0,   24,    6,  CKS_GOOD,    0,  -1,  ERR_NONE));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) build_segment(plan[r]);
    dir_items = built_items;
    send_all();
    // Hold off the next request until every directed result is out.
    push_req <= 1'b0;
    wait_for_results();
    @(posedge clk_i);

    while (built_items < dir_items + RANDOM_ITEMS) begin
      chunk = $urandom_range(2, 12);
      repeat (chunk) begin
        six = 1'($urandom_range(0, 1));
        sp = mk(six, six, $urandom_range(0, 3), six ? 8 : 2, $urandom_range(20, 80), 5,
                CKS_GOOD, $urandom_range(0, 2) == 0, -1, ERR_NONE);
        if ($urandom_range(0, 9) == 0) sp.len = $urandom_range(81, 400);
        if ($urandom_range(0, 5) == 0) sp.n_addr = $urandom_range(0, 10);
        sp.nib = $urandom_range(5, (sp.len >= 60) ? 15 : sp.len / 4);
        kind = $urandom_range(0, 99);
        if (kind >= 95) begin
          sp.s6 = 1'($urandom_range(0, 1));
          sp.d6 = 1'($urandom_range(0, 1));
          sp.len = $urandom_range(1, 100);
          sp.nib = $urandom_range(0, 15);
          sp.cks = CKS_RANDOM;
        end else if (kind >= 90) begin
          sp.d6 = !sp.s6;
        end else if (kind >= 84) begin
          if ($urandom_range(0, 1) == 1) begin
            sp.nib = $urandom_range(0, 4);
          end else begin
            sp.len = $urandom_range(20, 56);
            sp.nib = $urandom_range(sp.len / 4 + 1, 15);
          end
        end else if (kind >= 78) begin
          sp.len = $urandom_range(1, 19);
        end else if (kind >= 70) begin
          sp.cks = CKS_FLIPPED;
        end
        build_segment(sp);
      end
      send_all();
      if ($urandom_range(0, 2) == 0) begin
        push_req <= 1'b0;
        wait_for_results();
        @(posedge clk_i);
      end
    end

    push_req <= 1'b0;
    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tcp_segment_header_checker verification clean");
    end else begin
      $display("tcp_segment_header_checker verification failed");
    end
    $finish;
  end

endmodule
